>>> hw/rtl/wodz_pkg.sv
`default_nettype none

package wodz_pkg;

  localparam int unsigned POS_W     = 16;
  localparam int unsigned D2_W      = 20;
  localparam int unsigned OFS_W     = 32;
  localparam int unsigned MC_W      = OFS_W + 1;
  localparam int unsigned ACC_W     = MC_W + 1;
  localparam int unsigned MPL_W     = 16;
  localparam int unsigned CNT_W     = $clog2(MPL_W);
  localparam int unsigned V_W       = (D2_W - 1) + (MPL_W - 1);
  localparam int unsigned BAND_W    = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 4 * POS_W;
  localparam int unsigned OUT_DATA_W = 2 * OFS_W;

  localparam logic [OFS_W-1:0] SAT_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic [OFS_W-1:0] SAT_MIN = {1'b1, {(OFS_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONITOR_LEFT    = 3'd0,
    REG_MONITOR_TOP     = 3'd1,
    REG_MONITOR_WIDTH   = 3'd2,
    REG_MONITOR_HEIGHT  = 3'd3,
    REG_GAIN_X          = 3'd4,
    REG_GAIN_Y          = 3'd5,
    REG_DEAD_BAND       = 3'd6,
    REG_SMOOTHING_ALPHA = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]  monitor_left;
    logic [POS_W-1:0]  monitor_top;
    logic [POS_W-1:0]  monitor_width;
    logic [POS_W-1:0]  monitor_height;
    logic [MPL_W-1:0]  gain_x;
    logic [MPL_W-1:0]  gain_y;
    logic [BAND_W-1:0] dead_band;
    logic [MPL_W-1:0]  smoothing_alpha;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    monitor_left:    16'd0,
    monitor_top:     16'd0,
    monitor_width:   16'd1920,
    monitor_height:  16'd1080,
    gain_x:          16'd256,
    gain_y:          16'd256,
    dead_band:       24'd0,
    smoothing_alpha: 16'd0
  };

  typedef struct packed {
    logic [POS_W-1:0] window_x;
    logic [POS_W-1:0] window_y;
    logic [POS_W-1:0] window_width;
    logic [POS_W-1:0] window_height;
    logic             geometry_ok;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [D2_W-1:0] d2x;
    logic [D2_W-1:0] d2y;
  } front_t;

  typedef struct packed {
    logic             start;
    logic [MC_W-1:0]  mcand;
    logic [MPL_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] acc;
    logic [MPL_W-1:0] low;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT,
    ST_MUL,
    ST_SHAPE,
    ST_EMA_UPD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_GAIN_X,
    PH_GAIN_Y,
    PH_EMA_X,
    PH_EMA_Y
  } phase_e;

endpackage

`default_nettype wire

>>> hw/rtl/wodz_front.sv
`default_nettype none

module wodz_front
  import wodz_pkg::*;
(
  input  item_t  item_i,
  input  cfg_t   cfg_i,
  output front_t front_o
);

  logic [D2_W-1:0] c2x, c2y, lox, loy, hix, hiy, m2x, m2y;
  logic            in_x, in_y;

  always_comb begin
    c2x = {{(D2_W-POS_W-1){item_i.window_x[POS_W-1]}}, item_i.window_x, 1'b0}
        + {{(D2_W-POS_W){1'b0}}, item_i.window_width};
    c2y = {{(D2_W-POS_W-1){item_i.window_y[POS_W-1]}}, item_i.window_y, 1'b0}
        + {{(D2_W-POS_W){1'b0}}, item_i.window_height};
    lox = {{(D2_W-POS_W-1){cfg_i.monitor_left[POS_W-1]}}, cfg_i.monitor_left, 1'b0};
    loy = {{(D2_W-POS_W-1){cfg_i.monitor_top[POS_W-1]}}, cfg_i.monitor_top, 1'b0};
    hix = lox + {{(D2_W-POS_W-1){1'b0}}, cfg_i.monitor_width, 1'b0};
    hiy = loy + {{(D2_W-POS_W-1){1'b0}}, cfg_i.monitor_height, 1'b0};
    m2x = lox + {{(D2_W-POS_W){1'b0}}, cfg_i.monitor_width};
    m2y = loy + {{(D2_W-POS_W){1'b0}}, cfg_i.monitor_height};
    in_x = ($signed(c2x) >= $signed(lox)) && ($signed(c2x) <= $signed(hix));
    in_y = ($signed(c2y) >= $signed(loy)) && ($signed(c2y) <= $signed(hiy));
    front_o.valid = item_i.geometry_ok && (item_i.window_width != '0)
                 && (item_i.window_height != '0) && in_x && in_y;
    front_o.d2x = c2x - m2x;
    front_o.d2y = c2y - m2y;
  end

endmodule

`default_nettype wire

>>> hw/rtl/wodz_serial_mul.sv
`default_nettype none

module wodz_serial_mul
  import wodz_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [MC_W-1:0]  mcand_q;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [MPL_W-1:0] mq_q, mq_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [ACC_W:0]   sum;

  always_comb begin
    sum = {acc_q[ACC_W-1], acc_q}
        + (mq_q[0] ? {{(ACC_W+1-MC_W){mcand_q[MC_W-1]}}, mcand_q} : '0);
    acc_d = sum[ACC_W:1];
    mq_d  = {sum[0], mq_q[MPL_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MPL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= req_i.mcand;
      acc_q   <= '0;
      mq_q    <= req_i.mplier;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mq_q  <= mq_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.low  = mq_q;

endmodule

`default_nettype wire

>>> hw/rtl/wodz_shape.sv
`default_nettype none

module wodz_shape
  import wodz_pkg::*;
(
  input  mul_rsp_t          rsp_i,
  input  logic [BAND_W-1:0] dead_band_i,
  output logic [OFS_W-1:0]  value_o
);

  logic [V_W-1:0]   half;
  logic [OFS_W-1:0] sat;
  logic [OFS_W:0]   sat_ext, band_ext, neg_band;
  logic             dead;

  always_comb begin
    half = {rsp_i.acc[D2_W-2:0], rsp_i.low[MPL_W-1:1]};
    if ((half[V_W-1:OFS_W-1] == '0) || (half[V_W-1:OFS_W-1] == '1)) begin
      sat = half[OFS_W-1:0];
    end else if (half[V_W-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
    sat_ext  = {sat[OFS_W-1], sat};
    band_ext = {{(OFS_W+1-BAND_W){1'b0}}, dead_band_i};
    neg_band = '0 - band_ext;
    if (sat[OFS_W-1]) begin
      dead = $signed(sat_ext) >= $signed(neg_band);
    end else begin
      dead = sat_ext <= band_ext;
    end
    value_o = dead ? '0 : sat;
  end

endmodule

`default_nettype wire

>>> hw/rtl/window_offset_deadzone_ema.sv
`default_nettype none
// Window offset with deadzone and exponential smoothing.
// Input stream s_axis: one transaction per window sample; tdata carries the
// window rectangle, tuser the geometry-ok flag. Output stream m_axis: one
// transaction per input; tdata carries the two offsets, tuser the
// sample-valid flag (offsets are zero when it is low).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; any
// write restarts smoothing from the next valid sample.
// All products run through one shift-add multiplier that retires one
// multiplier bit per cycle. A rejected sample skips the multiplier; a valid
// sample takes two gain products, and two more alpha products once
// smoothing is active and seeded. One item is in flight at a time; a new
// item can be taken in the cycle after its predecessor moves into the
// output register. The output register holds a finished transaction while
// m_axis_tready_i is low; the next item is still accepted and processed,
// and waits for the register to drain. Reset loads the register defaults,
// clears the smoothing state and empties the output register.
module window_offset_deadzone_ema
  import wodz_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // window_x, window_y, window_width, window_height
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // geometry_ok
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // offset_x, offset_y
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // sample_valid
  output logic                  m_axis_tuser_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  state_e   state_q, state_d;
  phase_e   phase_q, phase_d;
  cfg_t     cfg_q;
  item_t    item_q;
  front_t   front;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic [D2_W-1:0]  d2y_q;
  logic [OFS_W-1:0] vx_q, vy_q, shape_v;
  logic [OFS_W-1:0] smooth_x_q, smooth_y_q, ema_sum;
  logic             seeded_q, alpha_on, ema_go, out_free, s_accept;
  logic             res_sv_q, out_sv_q, out_valid_q;
  logic [OFS_W-1:0] res_x_q, res_y_q, out_x_q, out_y_q;

  wodz_front u_front (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .front_o(front)
  );

  wodz_serial_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  wodz_shape u_shape (
    .rsp_i      (mul_rsp),
    .dead_band_i(cfg_q.dead_band),
    .value_o    (shape_v)
  );

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign alpha_on = cfg_q.smoothing_alpha != '0;
  assign ema_go   = alpha_on && seeded_q;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign ema_sum  = (phase_q == PH_EMA_X ? smooth_x_q : smooth_y_q)
                  + mul_rsp.acc[OFS_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_accept) state_d = ST_FRONT;
      ST_FRONT:   state_d = front.valid ? ST_MUL : ST_DONE;
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_d = (phase_q == PH_EMA_X || phase_q == PH_EMA_Y) ? ST_EMA_UPD : ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        if (phase_q == PH_GAIN_X || ema_go) state_d = ST_MUL;
        else state_d = ST_DONE;
      end
      ST_EMA_UPD: state_d = (phase_q == PH_EMA_X) ? ST_MUL : ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_req.start   = 1'b0;
    mul_req.mcand   = {{(MC_W-D2_W){front.d2x[D2_W-1]}}, front.d2x};
    mul_req.mplier  = cfg_q.gain_x;
    phase_d         = phase_q;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_FRONT: begin
        mul_req.start = front.valid;
        phase_d       = PH_GAIN_X;
      end
      ST_SHAPE: begin
        if (phase_q == PH_GAIN_X) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = {{(MC_W-D2_W){d2y_q[D2_W-1]}}, d2y_q};
          mul_req.mplier = cfg_q.gain_y;
          phase_d        = PH_GAIN_Y;
        end else if (ema_go) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = {vx_q[OFS_W-1], vx_q} - {smooth_x_q[OFS_W-1], smooth_x_q};
          mul_req.mplier = cfg_q.smoothing_alpha;
          phase_d        = PH_EMA_X;
        end
      end
      ST_EMA_UPD: begin
        if (phase_q == PH_EMA_X) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = {vy_q[OFS_W-1], vy_q} - {smooth_y_q[OFS_W-1], smooth_y_q};
          mul_req.mplier = cfg_q.smoothing_alpha;
          phase_d        = PH_EMA_Y;
        end
      end
      ST_MUL, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_GAIN_X;
      cfg_q       <= CFG_RESET;
      seeded_q    <= 1'b0;
      smooth_x_q  <= '0;
      smooth_y_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        seeded_q <= 1'b0;
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_MONITOR_LEFT:    cfg_q.monitor_left    <= cfg_data_i[POS_W-1:0];
          REG_MONITOR_TOP:     cfg_q.monitor_top     <= cfg_data_i[POS_W-1:0];
          REG_MONITOR_WIDTH:   cfg_q.monitor_width   <= cfg_data_i[POS_W-1:0];
          REG_MONITOR_HEIGHT:  cfg_q.monitor_height  <= cfg_data_i[POS_W-1:0];
          REG_GAIN_X:          cfg_q.gain_x          <= cfg_data_i[MPL_W-1:0];
          REG_GAIN_Y:          cfg_q.gain_y          <= cfg_data_i[MPL_W-1:0];
          REG_DEAD_BAND:       cfg_q.dead_band       <= cfg_data_i[BAND_W-1:0];
          REG_SMOOTHING_ALPHA: cfg_q.smoothing_alpha <= cfg_data_i[MPL_W-1:0];
          default: ;
        endcase
      end else if (state_q == ST_FRONT && !front.valid) begin
        seeded_q <= 1'b0;
      end else if (state_q == ST_SHAPE && phase_q == PH_GAIN_Y) begin
        if (!alpha_on) begin
          seeded_q <= 1'b0;
        end else if (!seeded_q) begin
          seeded_q   <= 1'b1;
          smooth_x_q <= vx_q;
          smooth_y_q <= shape_v;
        end
      end else if (state_q == ST_EMA_UPD) begin
        if (phase_q == PH_EMA_X) smooth_x_q <= ema_sum;
        else smooth_y_q <= ema_sum;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.window_x      <= s_axis_tdata_i[POS_W-1:0];
      item_q.window_y      <= s_axis_tdata_i[2*POS_W-1:POS_W];
      item_q.window_width  <= s_axis_tdata_i[3*POS_W-1:2*POS_W];
      item_q.window_height <= s_axis_tdata_i[4*POS_W-1:3*POS_W];
      item_q.geometry_ok   <= s_axis_tuser_i;
    end
    if (state_q == ST_FRONT) begin
      d2y_q <= front.d2y;
      if (!front.valid) begin
        res_sv_q <= 1'b0;
        res_x_q  <= '0;
        res_y_q  <= '0;
      end
    end
    if (state_q == ST_SHAPE) begin
      if (phase_q == PH_GAIN_X) begin
        vx_q <= shape_v;
      end else begin
        vy_q <= shape_v;
        if (!ema_go) begin
          res_sv_q <= 1'b1;
          res_x_q  <= vx_q;
          res_y_q  <= shape_v;
        end
      end
    end
    if (state_q == ST_EMA_UPD && phase_q == PH_EMA_Y) begin
      res_sv_q <= 1'b1;
      res_x_q  <= smooth_x_q;
      res_y_q  <= ema_sum;
    end
    if (state_q == ST_DONE && out_free) begin
      out_sv_q <= res_sv_q;
      out_x_q  <= res_x_q;
      out_y_q  <= res_y_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_sv_q;

endmodule

`default_nettype wire

>>> hw/rtl/wodz_checker.sv
`default_nettype none

module wodz_checker
  import wodz_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("output payload changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("offsets nonzero on invalid sample");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

endmodule

bind window_offset_deadzone_ema wodz_checker u_wodz_checker (.*);

`default_nettype wire

>>> tb/tb_window_offset_deadzone_ema.sv
module tb_window_offset_deadzone_ema
  import wodz_pkg::*;
();

  localparam longint OFS_HI = 64'sd2147483647;
  localparam longint OFS_LO = -64'sd2147483648;

  typedef struct packed {
    logic             sample_valid;
    logic [OFS_W-1:0] offset_x;
    logic [OFS_W-1:0] offset_y;
  } offset_t;

  class offset_scoreboard;
    cfg_t        regs;
    logic [31:0] ema_x;
    logic [31:0] ema_y;
    bit          seeded;
    offset_t     offsets_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned samples;
    int unsigned smoothed;
    int unsigned writes;

    function new();
      regs = CFG_RESET;
      ema_x = '0;
      ema_y = '0;
      seeded = 1'b0;
      mismatches = 0;
      checked = 0;
      samples = 0;
      smoothed = 0;
      writes = 0;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
      case (r)
        REG_MONITOR_LEFT:    regs.monitor_left = v[POS_W-1:0];
        REG_MONITOR_TOP:     regs.monitor_top = v[POS_W-1:0];
        REG_MONITOR_WIDTH:   regs.monitor_width = v[POS_W-1:0];
        REG_MONITOR_HEIGHT:  regs.monitor_height = v[POS_W-1:0];
        REG_GAIN_X:          regs.gain_x = v[MPL_W-1:0];
        REG_GAIN_Y:          regs.gain_y = v[MPL_W-1:0];
        REG_DEAD_BAND:       regs.dead_band = v[BAND_W-1:0];
        REG_SMOOTHING_ALPHA: regs.smoothing_alpha = v[MPL_W-1:0];
        default: ;
      endcase
      seeded = 1'b0;
      writes++;
    endfunction

    // scale, floor to Q.8, saturate, then apply the deadzone
    function longint shape_axis(longint d2, logic [MPL_W-1:0] gain);
      longint v;
      longint mag;
      v = (d2 * longint'(gain)) >>> 1;
      if (v > OFS_HI) v = OFS_HI;
      if (v < OFS_LO) v = OFS_LO;
      mag = (v < 0) ? -v : v;
      if (mag <= longint'(regs.dead_band)) v = 0;
      return v;
    endfunction

    function logic [31:0] blend(logic [31:0] prev, longint target);
      longint     s;
      longint     step;
      logic [63:0] sum;
      s = longint'($signed(prev));
      step = ((target - s) * longint'(regs.smoothing_alpha)) >>> 16;
      sum = s + step;
      return sum[31:0];
    endfunction

    function void note_window(item_t it);
      longint  wx, wy, ww, wh, ml, mt, mw, mh, cx2, cy2, vx, vy;
      logic [63:0] bx, by;
      bit      ok;
      offset_t e;
      wx = longint'($signed(it.window_x));
      wy = longint'($signed(it.window_y));
      ww = longint'(it.window_width);
      wh = longint'(it.window_height);
      ml = longint'($signed(regs.monitor_left));
      mt = longint'($signed(regs.monitor_top));
      mw = longint'(regs.monitor_width);
      mh = longint'(regs.monitor_height);
      cx2 = 2 * wx + ww;
      cy2 = 2 * wy + wh;
      ok = it.geometry_ok && ww != 0 && wh != 0 &&
           cx2 >= 2 * ml && cx2 <= 2 * ml + 2 * mw &&
           cy2 >= 2 * mt && cy2 <= 2 * mt + 2 * mh;
      e = '0;
      if (!ok) begin
        seeded = 1'b0;
      end else begin
        vx = shape_axis(cx2 - (2 * ml + mw), regs.gain_x);
        vy = shape_axis(cy2 - (2 * mt + mh), regs.gain_y);
        e.sample_valid = 1'b1;
        if (regs.smoothing_alpha != 0) begin
          if (!seeded) begin
            bx = vx;
            by = vy;
            ema_x = bx[31:0];
            ema_y = by[31:0];
            seeded = 1'b1;
          end else begin
            ema_x = blend(ema_x, vx);
            ema_y = blend(ema_y, vy);
          end
          e.offset_x = ema_x;
          e.offset_y = ema_y;
          smoothed++;
        end else begin
          seeded = 1'b0;
          bx = vx;
          by = vy;
          e.offset_x = bx[31:0];
          e.offset_y = by[31:0];
        end
      end
      offsets_due.push_back(e);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, label, $signed(want), $signed(got));
        mismatches++;
      end
    endfunction

    function void check_offset(logic valid, logic [OUT_DATA_W-1:0] data);
      offset_t e;
      if (offsets_due.size() == 0) begin
        $display("%0t: offset transaction with none expected, actual valid=%0b x=%0d y=%0d",
                 $time, valid, $signed(data[31:0]), $signed(data[63:32]));
        mismatches++;
        return;
      end
      e = offsets_due.pop_front();
      checked++;
      if (e.sample_valid) samples++;
      compare_field("sample_valid", 32'(e.sample_valid), 32'(valid));
      compare_field("offset_x", e.offset_x, data[31:0]);
      compare_field("offset_y", e.offset_y, data[63:32]);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  offset_scoreboard sb;
  bit               calm;
  int unsigned      settings;

  window_offset_deadzone_ema dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit gap_roll();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= !gap_roll();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_offset(m_axis_tuser_o, m_axis_tdata_o);
  end

  function automatic item_t window(int x, int y, int unsigned w, int unsigned h, bit ok);
    item_t it;
    it.window_x = x[15:0];
    it.window_y = y[15:0];
    it.window_width = w[15:0];
    it.window_height = h[15:0];
    it.geometry_ok = ok;
    return it;
  endfunction

  function automatic logic [POS_W-1:0] pick_size();
    if ($urandom_range(7) == 0) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(1, 400));
  endfunction

  function automatic longint pick_span(logic [POS_W-1:0] ext);
    longint span;
    span = 2 * longint'(ext);
    case ($urandom_range(7))
      0: return 0;
      1: return span;
      default: return longint'($urandom_range(0, int'(span)));
    endcase
  endfunction

  // aim the window centre inside the monitor, with some broken and noise windows
  function automatic item_t make_window(cfg_t c);
    item_t       it;
    int unsigned roll;
    int unsigned flaw;
    longint      cx, cy, wx, wy;
    logic [63:0] bx, by;
    roll = $urandom_range(99);
    it.window_x = 16'($urandom_range(16'hFFFF));
    it.window_y = 16'($urandom_range(16'hFFFF));
    it.window_width = 16'($urandom_range(16'hFFFF));
    it.window_height = 16'($urandom_range(16'hFFFF));
    it.geometry_ok = 1'($urandom_range(1));
    if (roll >= 85) return it;
    flaw = (roll >= 75) ? $urandom_range(3) : 4;
    it.geometry_ok = (flaw != 0);
    it.window_width = pick_size();
    it.window_height = pick_size();
    cx = 2 * longint'($signed(c.monitor_left)) + pick_span(c.monitor_width);
    cy = 2 * longint'($signed(c.monitor_top)) + pick_span(c.monitor_height);
    if (flaw == 3) begin
      if ($urandom_range(1)) cx = 2 * longint'($signed(c.monitor_left)) - 1;
      else cy = 2 * longint'($signed(c.monitor_top)) + 2 * longint'(c.monitor_height) + 1;
    end
    it.window_width[0] = cx[0];
    it.window_height[0] = cy[0];
    if (it.window_width == 0) it.window_width = 2;
    if (it.window_height == 0) it.window_height = 2;
    wx = (cx - longint'(it.window_width)) >>> 1;
    wy = (cy - longint'(it.window_height)) >>> 1;
    bx = wx;
    by = wy;
    it.window_x = bx[15:0];
    it.window_y = by[15:0];
    if (flaw == 1) it.window_width = '0;
    if (flaw == 2) it.window_height = '0;
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] reg_value(cfg_t c, cfg_reg_e r);
    case (r)
      REG_MONITOR_LEFT:    return CFG_W'(c.monitor_left);
      REG_MONITOR_TOP:     return CFG_W'(c.monitor_top);
      REG_MONITOR_WIDTH:   return CFG_W'(c.monitor_width);
      REG_MONITOR_HEIGHT:  return CFG_W'(c.monitor_height);
      REG_GAIN_X:          return CFG_W'(c.gain_x);
      REG_GAIN_Y:          return CFG_W'(c.gain_y);
      REG_DEAD_BAND:       return CFG_W'(c.dead_band);
      default:             return CFG_W'(c.smoothing_alpha);
    endcase
  endfunction

  function automatic cfg_t phase_cfg(int p);
    cfg_t c;
    c.monitor_left = 16'($urandom_range(16'hFFFF));
    c.monitor_top = 16'($urandom_range(16'hFFFF));
    c.monitor_width = 16'($urandom_range(1, 16'hFFFF));
    c.monitor_height = 16'($urandom_range(1, 16'hFFFF));
    c.gain_x = 16'($urandom_range(0, 1023));
    c.gain_y = 16'($urandom_range(0, 1023));
    c.dead_band = 24'($urandom_range(0, 256 * 50));
    c.smoothing_alpha = ($urandom_range(3) == 0) ? '0 : 16'($urandom_range(1, 16'hFFFF));
    case (p)
      0: begin
        c.monitor_left = 16'h8000;
        c.monitor_top = 16'h8000;
        c.monitor_width = 16'hFFFF;
        c.monitor_height = 16'hFFFF;
        c.gain_x = 16'hFFFF;
        c.gain_y = 16'hFFFF;
        c.dead_band = '0;
        c.smoothing_alpha = '0;
      end
      1: begin
        c.monitor_left = 16'h7FFF;
        c.monitor_top = 16'h7FFF;
        c.monitor_width = 16'd1;
        c.monitor_height = 16'd1;
        c.gain_x = 16'd1;
        c.gain_y = 16'hFFFF;
        c.dead_band = 24'hFFFFFF;
        c.smoothing_alpha = 16'hFFFF;
      end
      2: begin
        c = CFG_RESET;
        c.dead_band = 24'($urandom_range(0, 256 * 20));
        c.smoothing_alpha = 16'd1;
      end
      3: begin
        c.monitor_width = '0;
        c.monitor_height = '0;
        c.gain_x = '0;
        c.gain_y = 16'hFFFF;
        c.smoothing_alpha = 16'($urandom_range(1, 16'hFFFF));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic push_window(input item_t it);
    if (gap_roll()) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while (gap_roll());
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {it.window_height, it.window_width, it.window_y, it.window_x};
    s_axis_tuser_i <= it.geometry_ok;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_window(it);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.offsets_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_regs(input cfg_t c);
    cfg_reg_e r;
    r = REG_MONITOR_LEFT;
    repeat (r.num()) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r;
      cfg_data_i <= reg_value(c, r);
      @(posedge clk_i);
      sb.write_reg(r, reg_value(c, r));
      @(negedge clk_i);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    cfg_t c;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    calm = 1'b0;
    settings = 1;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: centre, edges, one half-pixel outside, rejected windows
    push_window(window(860, 440, 200, 200, 1'b1));
    push_window(window(-50, -50, 100, 100, 1'b1));
    push_window(window(1870, 1030, 100, 100, 1'b1));
    push_window(window(-50, 440, 99, 200, 1'b1));
    push_window(window(860, 1030, 200, 101, 1'b1));
    push_window(window(860, 440, 200, 200, 1'b0));
    push_window(window(860, 440, 0, 200, 1'b1));
    push_window(window(860, 440, 200, 0, 1'b1));
    push_window(window(-32768, 32767, 65535, 65535, 1'b1));
    push_window(window(32767, -32768, 1, 1, 1'b1));
    push_window(window(100, 100, 1, 3, 1'b1));
    settle();

    // zero gain on x, odd gain on y, deadzone, half-weight smoothing
    c = CFG_RESET;
    c.gain_x = '0;
    c.gain_y = 16'd255;
    c.dead_band = 24'd25600;
    c.smoothing_alpha = 16'h8000;
    load_regs(c);
    push_window(window(1500, 900, 100, 100, 1'b1));
    push_window(window(0, 0, 100, 100, 1'b1));
    push_window(window(910, 490, 100, 100, 1'b1));
    push_window(window(910, 530, 100, 100, 1'b0));
    push_window(window(910, 530, 101, 101, 1'b1));
    push_window(window(100, -50, 100, 101, 1'b1));
    settle();
    c.smoothing_alpha = '0;
    load_regs(c);
    push_window(window(100, -50, 100, 101, 1'b1));
    push_window(window(1870, 1030, 100, 100, 1'b1));
    settle();

    for (int p = 0; p < 8; p++) begin
      calm = (p == 4);
      c = phase_cfg(p);
      load_regs(c);
      repeat (50) push_window(make_window(sb.regs));
      settle();
    end
    calm = 1'b0;

    repeat (80) @(posedge clk_i);
    $display("checked %0d offset transactions: %0d valid samples, %0d smoothed",
             sb.checked, sb.samples, sb.smoothed);
    $display("%0d register writes over %0d settings, %0d mismatches",
             sb.writes, settings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
